// ----- hw/rtl/dsc_pkg.sv -----
// Constants and the head-count reciprocal table for the CHS geometry block.
package dsc_pkg;

  localparam int SizeW   = 41;
  localparam int SecW    = 28;  // clamped sector count
  localparam int RawSecW = SizeW - 9;
  localparam int Q17W    = 24;
  localparam int Q31W    = 24;
  localparam int Q63W    = 23;
  localparam int Q255W   = 21;
  localparam int CxhW    = 21;
  localparam int CylW    = 16;
  localparam int HeadW   = 5;
  localparam int SptW    = 8;
  localparam int RcpW    = 19;
  localparam int RcpShift = 20;
  localparam int DivShift = 36;
  localparam int MulW    = SecW + 32;

  localparam logic [SecW-1:0] MaxSectors = SecW'(65535 * 16 * 255);
  localparam logic [SecW-1:0] BigSectors = SecW'(65535 * 16 * 63);

  // ceil(2^36 / d): exact quotient for any 28-bit dividend
  localparam logic [31:0] Recip17  = 32'd4042322161;
  localparam logic [31:0] Recip31  = 32'd2216757315;
  localparam logic [31:0] Recip63  = 32'd1090785346;
  localparam logic [31:0] Recip255 = 32'd269488145;

  localparam logic [SptW-1:0] Spt17  = 8'd17;
  localparam logic [SptW-1:0] Spt31  = 8'd31;
  localparam logic [SptW-1:0] Spt63  = 8'd63;
  localparam logic [SptW-1:0] Spt255 = 8'd255;

  localparam logic [HeadW-1:0] MinHeads = 5'd4;
  localparam logic [HeadW-1:0] MaxHeads = 5'd16;
  localparam logic [CxhW-1:0]  CxhLimit16 = CxhW'(16 * 1024);

  // ceil(2^20 / h), exact for dividends below 2^14 and h up to 16
  function automatic logic [RcpW-1:0] head_recip(input logic [HeadW-1:0] h);
    logic [RcpW-1:0] r;
    unique case (h)
      5'd4:    r = 19'd262144;
      5'd5:    r = 19'd209716;
      5'd6:    r = 19'd174763;
      5'd7:    r = 19'd149797;
      5'd8:    r = 19'd131072;
      5'd9:    r = 19'd116509;
      5'd10:   r = 19'd104858;
      5'd11:   r = 19'd95326;
      5'd12:   r = 19'd87382;
      5'd13:   r = 19'd80660;
      5'd14:   r = 19'd74899;
      5'd15:   r = 19'd69906;
      5'd16:   r = 19'd65536;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/disk_size_to_chs_geometry.sv -----
// Virtual disk CHS geometry: byte size in, cylinders/heads/sectors-per-track out.
//
// Input channel: in_valid / in_stall with disk_size_bytes. A size is taken at
// each rising edge where in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with cylinders, heads and
// sectors_per_track. One result leaves per accepted size, in order.
//
// Four register stages: clamp the sector count, divide it by 17, 31, 63 and
// 255 through reciprocal multipliers, choose the geometry, then divide by the
// head count through a reciprocal table. One size can enter every cycle while
// in_stall is low.
//
// A stall at the output holds the output register; each earlier stage keeps
// advancing while it has an empty slot ahead of it, so in_stall rises only
// when all four stages hold data and out_stall is high.
// Reset clears the stage valid bits; data registers are not reset.
module disk_size_to_chs_geometry (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [dsc_pkg::SizeW-1:0]      disk_size_bytes,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [dsc_pkg::CylW-1:0]       cylinders,
  output logic [dsc_pkg::HeadW-1:0]      heads,
  output logic [dsc_pkg::SptW-1:0]       sectors_per_track
);

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !out_valid || !out_stall;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_stall = !rdy1;

  // stage 1: sector count, clamped
  logic [dsc_pkg::RawSecW-1:0] raw_sec;
  logic [dsc_pkg::SecW-1:0]    sec_next, sec;
  logic                        big_next, big1;

  assign raw_sec = disk_size_bytes[dsc_pkg::SizeW-1:9];

  always_comb begin
    if (raw_sec > dsc_pkg::RawSecW'(dsc_pkg::MaxSectors)) begin
      sec_next = dsc_pkg::MaxSectors;
    end else begin
      sec_next = raw_sec[dsc_pkg::SecW-1:0];
    end
    big_next = (sec_next >= dsc_pkg::BigSectors);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1 && in_valid) begin
      sec  <= sec_next;
      big1 <= big_next;
    end
  end

  // stage 2: quotients by each sectors-per-track candidate
  logic [dsc_pkg::MulW-1:0]  p17, p31, p63, p255;
  logic [dsc_pkg::Q17W-1:0]  q17;
  logic [dsc_pkg::Q31W-1:0]  q31;
  logic [dsc_pkg::Q63W-1:0]  q63;
  logic [dsc_pkg::Q255W-1:0] q255;
  logic                      big2;

  assign p17  = dsc_pkg::MulW'(sec) * dsc_pkg::MulW'(dsc_pkg::Recip17);
  assign p31  = dsc_pkg::MulW'(sec) * dsc_pkg::MulW'(dsc_pkg::Recip31);
  assign p63  = dsc_pkg::MulW'(sec) * dsc_pkg::MulW'(dsc_pkg::Recip63);
  assign p255 = dsc_pkg::MulW'(sec) * dsc_pkg::MulW'(dsc_pkg::Recip255);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      q17  <= p17[dsc_pkg::DivShift +: dsc_pkg::Q17W];
      q31  <= p31[dsc_pkg::DivShift +: dsc_pkg::Q31W];
      q63  <= p63[dsc_pkg::DivShift +: dsc_pkg::Q63W];
      q255 <= p255[dsc_pkg::DivShift +: dsc_pkg::Q255W];
      big2 <= big1;
    end
  end

  // stage 3: pick the geometry
  logic [dsc_pkg::Q17W-1:0]  q17_up;
  logic [dsc_pkg::Q17W-11:0] hds_raw;
  logic [dsc_pkg::HeadW-1:0] hds17;
  logic                      fail17;
  logic [dsc_pkg::SptW-1:0]  spt_next, spt3;
  logic [dsc_pkg::HeadW-1:0] hds_next, hds3;
  logic [dsc_pkg::CxhW-1:0]  cxh_next, cxh3;

  always_comb begin
    q17_up  = q17 + dsc_pkg::Q17W'(1023);
    hds_raw = q17_up[dsc_pkg::Q17W-1:10];
    if (hds_raw < (dsc_pkg::Q17W-10)'(dsc_pkg::MinHeads)) begin
      hds17 = dsc_pkg::MinHeads;
    end else begin
      hds17 = hds_raw[dsc_pkg::HeadW-1:0];
    end
    fail17 = (hds_raw > (dsc_pkg::Q17W-10)'(dsc_pkg::MaxHeads)) ||
             (q17 >= {9'd0, hds17, 10'd0});

    if (big2) begin
      spt_next = dsc_pkg::Spt255;
      hds_next = dsc_pkg::MaxHeads;
      cxh_next = q255;
    end else if (!fail17) begin
      spt_next = dsc_pkg::Spt17;
      hds_next = hds17;
      cxh_next = q17[dsc_pkg::CxhW-1:0];
    end else if (q31 < dsc_pkg::Q31W'(dsc_pkg::CxhLimit16)) begin
      spt_next = dsc_pkg::Spt31;
      hds_next = dsc_pkg::MaxHeads;
      cxh_next = q31[dsc_pkg::CxhW-1:0];
    end else begin
      spt_next = dsc_pkg::Spt63;
      hds_next = dsc_pkg::MaxHeads;
      cxh_next = dsc_pkg::CxhW'(q63);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3 && v2) begin
      spt3 <= spt_next;
      hds3 <= hds_next;
      cxh3 <= cxh_next;
    end
  end

  // stage 4: cylinders = cylinders-times-heads / heads
  logic [32:0]               cyl_prod;
  logic [dsc_pkg::CylW-1:0]  cyl_next;

  assign cyl_prod = 33'(cxh3[13:0]) * 33'(dsc_pkg::head_recip(hds3));

  always_comb begin
    if (hds3 == dsc_pkg::MaxHeads) begin
      cyl_next = dsc_pkg::CylW'(cxh3[dsc_pkg::CxhW-1:4]);
    end else begin
      cyl_next = dsc_pkg::CylW'(cyl_prod[32:dsc_pkg::RcpShift]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy4) begin
      out_valid <= v3;
    end
    if (rdy4 && v3) begin
      cylinders         <= cyl_next;
      heads             <= hds3;
      sectors_per_track <= spt3;
    end
  end

`ifndef SYNTHESIS
  // a stall at the input means every stage is full and the output is held
  a_full_on_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && v3 && out_valid && out_stall))
    else $error("input stalled without a full pipeline");

  a_heads_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heads >= dsc_pkg::MinHeads && heads <= dsc_pkg::MaxHeads))
    else $error("head count out of range");

  a_spt_heads: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sectors_per_track != dsc_pkg::Spt17) |-> (heads == dsc_pkg::MaxHeads))
    else $error("large sectors-per-track without 16 heads");

  a_spt_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sectors_per_track == dsc_pkg::Spt17 ||
                   sectors_per_track == dsc_pkg::Spt31 ||
                   sectors_per_track == dsc_pkg::Spt63 ||
                   sectors_per_track == dsc_pkg::Spt255))
    else $error("bad sectors-per-track value");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(v3))
    else $error("output valid without an item in stage 3");
`endif

endmodule
